[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the WebSocket deframer.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

[rtl/wsd_pkg.sv]
// Types and codes for the WebSocket frame deframer.
// Used by wsd_parse and websocket_frame_deframer; depends on nothing.
package wsd_pkg;

	typedef enum logic [2:0] {
		PH_FIRST,
		PH_LEN,
		PH_EXT,
		PH_KEY,
		PH_DATA,
		PH_DEAD
	} phase_t;

	// result kinds
	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	// frame types
	localparam logic [2:0] FT_TEXT      = 3'd0;
	localparam logic [2:0] FT_TEXT_FRAG = 3'd1;
	localparam logic [2:0] FT_BIN       = 3'd2;
	localparam logic [2:0] FT_BIN_FRAG  = 3'd3;
	localparam logic [2:0] FT_PING      = 3'd4;
	localparam logic [2:0] FT_PONG      = 3'd5;

	// error codes
	localparam logic [1:0] ERR_OPCODE = 2'd0;
	localparam logic [1:0] ERR_LIMIT  = 2'd1;
	localparam logic [1:0] ERR_TOPBIT = 2'd2;

	// opcodes
	localparam logic [3:0] OP_CONT = 4'h0;
	localparam logic [3:0] OP_TEXT = 4'h1;
	localparam logic [3:0] OP_BIN  = 4'h2;
	localparam logic [3:0] OP_PING = 4'h9;
	localparam logic [3:0] OP_PONG = 4'hA;

	// length codes and header byte counts
	localparam logic [6:0] LEN_SHORT_MAX = 7'd125;
	localparam logic [6:0] LEN_CODE_16   = 7'd126;
	localparam logic [3:0] EXT16_BYTES   = 4'd2;
	localparam logic [3:0] EXT64_BYTES   = 4'd8;
	localparam logic [3:0] KEY_BYTES     = 4'd4;

	localparam logic [30:0] MAX_PAYLOAD_RST = 31'h7FFF_FFFF;

	typedef struct packed {
		logic        hit;
		logic [1:0]  kind;
		logic [2:0]  frame_type;
		logic [1:0]  error_code;
		logic [62:0] payload_length;
		logic        was_masked;
		logic [7:0]  payload_byte;
		logic        last;
	} res_t;

endpackage

[rtl/wsd_parse.sv]
// Header and payload parser of the WebSocket deframer: frame state and
// one-byte-per-step decode. Depends on wsd_pkg.
module wsd_parse import wsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  byte_in,
	input  logic [30:0] max_payload,
	output res_t        res,
	output logic        dead
);

	phase_t      phase_q, phase_d;
	logic [2:0]  ftype_q, ftype_d;
	logic        mask_q, mask_d;
	logic [3:0]  hidx_q, hidx_d;
	logic [63:0] len_q, len_d;
	logic [31:0] key_q, key_d;
	logic [62:0] rem_q, rem_d;
	logic [1:0]  kidx_q, kidx_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			ftype_q <= '0;
			mask_q  <= 1'b0;
			hidx_q  <= '0;
			len_q   <= '0;
			key_q   <= '0;
			rem_q   <= '0;
			kidx_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			ftype_q <= ftype_d;
			mask_q  <= mask_d;
			hidx_q  <= hidx_d;
			len_q   <= len_d;
			key_q   <= key_d;
			rem_q   <= rem_d;
			kidx_q  <= kidx_d;
		end
	end

	always_comb begin
		logic [63:0] len_new;
		logic        len_chk;
		logic        fin_hdr;
		logic [62:0] fin_len;
		logic [7:0]  kb;

		phase_d = phase_q;
		ftype_d = ftype_q;
		mask_d  = mask_q;
		hidx_d  = hidx_q;
		len_d   = len_q;
		key_d   = key_q;
		rem_d   = rem_q;
		kidx_d  = kidx_q;
		res     = '0;
		len_new = len_q;
		len_chk = 1'b0;
		fin_hdr = 1'b0;
		fin_len = len_q[62:0];
		kb      = key_q[{kidx_q, 3'b000} +: 8];

		unique case (phase_q)
			PH_FIRST: begin
				phase_d = PH_LEN;
				unique case (byte_in[3:0])
					OP_CONT, OP_TEXT: ftype_d = byte_in[7] ? FT_TEXT : FT_TEXT_FRAG;
					OP_BIN:           ftype_d = byte_in[7] ? FT_BIN : FT_BIN_FRAG;
					OP_PING:          ftype_d = FT_PING;
					OP_PONG:          ftype_d = FT_PONG;
					default: begin
						phase_d        = PH_DEAD;
						res.hit        = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_OPCODE;
					end
				endcase
			end
			PH_LEN: begin
				mask_d = byte_in[7];
				if (byte_in[6:0] <= LEN_SHORT_MAX) begin
					len_new = {57'd0, byte_in[6:0]};
					len_chk = 1'b1;
				end else begin
					len_new = '0;
					hidx_d  = (byte_in[6:0] == LEN_CODE_16) ? EXT16_BYTES : EXT64_BYTES;
					phase_d = PH_EXT;
				end
				len_d = len_new;
			end
			PH_EXT: begin
				len_new = {len_q[55:0], byte_in};
				len_d   = len_new;
				hidx_d  = hidx_q - 4'd1;
				if (hidx_q == 4'd1) begin
					if (len_new[63]) begin
						phase_d        = PH_DEAD;
						res.hit        = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_TOPBIT;
					end else begin
						len_chk = 1'b1;
					end
				end
			end
			PH_KEY: begin
				// first key byte ends up in bits 7..0
				key_d  = {byte_in, key_q[31:8]};
				hidx_d = hidx_q - 4'd1;
				if (hidx_q == 4'd1) begin
					fin_hdr = 1'b1;
				end
			end
			PH_DATA: begin
				kidx_d           = kidx_q + 2'd1;
				rem_d            = rem_q - 63'd1;
				res.hit          = 1'b1;
				res.kind         = KIND_PAYLOAD;
				res.frame_type   = ftype_q;
				res.was_masked   = mask_q;
				res.payload_byte = mask_q ? (byte_in ^ kb) : byte_in;
				res.last         = (rem_q == 63'd1);
				if (rem_q == 63'd1) begin
					phase_d = PH_FIRST;
				end
			end
			PH_DEAD: begin
				phase_d = PH_DEAD;
			end
			default: begin
				phase_d = PH_DEAD;
			end
		endcase

		// length is known: check the limit, then go to the key or finish
		if (len_chk) begin
			if (len_new > {33'd0, max_payload}) begin
				phase_d            = PH_DEAD;
				res.hit            = 1'b1;
				res.kind           = KIND_ERROR;
				res.error_code     = ERR_LIMIT;
				res.payload_length = len_new[62:0];
			end else if (mask_d) begin
				phase_d = PH_KEY;
				hidx_d  = KEY_BYTES;
			end else begin
				fin_hdr = 1'b1;
				fin_len = len_new[62:0];
			end
		end

		if (fin_hdr) begin
			rem_d              = fin_len;
			kidx_d             = '0;
			hidx_d             = '0;
			phase_d            = (fin_len == 63'd0) ? PH_FIRST : PH_DATA;
			res.hit            = 1'b1;
			res.kind           = KIND_HEADER;
			res.frame_type     = ftype_d;
			res.payload_length = fin_len;
			res.was_masked     = mask_d;
		end
	end

	assign dead = (phase_q == PH_DEAD);

endmodule

[rtl/websocket_frame_deframer.sv]
// WebSocket frame deframer, top level: input register, parser, result register.
// A byte passes through the input register, and its result, if any, through the result register.
// Throughput: one byte per cycle while the result side does not stall, with one parser state update per byte.
// Reset (arst_n low, asynchronous) waits for a first header byte, clears any
// latched error and sets max_payload to 2^31-1. Depends on wsd_pkg, wsd_parse.
`include "assert_macros.svh"

module websocket_frame_deframer import wsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: payload length limit
	input  logic        cfg_we,
	input  logic [30:0] cfg_data,
	// raw stream word in
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  stream_byte,
	// result word out
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  kind,
	output logic [2:0]  frame_type,
	output logic [1:0]  error_code,
	output logic [62:0] payload_length,
	output logic        was_masked,
	output logic [7:0]  payload_byte,
	output logic        last
);

	logic [30:0] max_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        valid_s2;
	res_t        res_s2;
	res_t        res;
	logic        out_free;
	logic        step;
	logic        dead;

	// The limit register. The user must write it only while the pipe is empty; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_PAYLOAD_RST;
		end else if (cfg_we) begin
			max_q <= cfg_data;
		end
	end

	// The result register can load when empty or when its word leaves now.
	assign out_free   = !valid_s2 || !result_stall;
	// Advance the parser whenever the held byte can drop its result, if any.
	// A byte with no result still needs a free slot, which keeps this simple
	// and costs nothing at full rate since the slot frees every cycle.
	assign step       = valid_s1 && out_free;
	assign byte_stall = valid_s1 && !out_free;

	// Input register: hold the byte while the result side stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1 <= stream_byte;
		end
	end

	wsd_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.byte_in     (byte_s1),
		.max_payload (max_q),
		.res         (res),
		.dead        (dead)
	);

	// Result register: load a word when the parser yields one, else drain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= step && res.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && step && res.hit) begin
			res_s2 <= res;
		end
	end

	assign result_valid   = valid_s2;
	assign kind           = res_s2.kind;
	assign frame_type     = res_s2.frame_type;
	assign error_code     = res_s2.error_code;
	assign payload_length = res_s2.payload_length;
	assign was_masked     = res_s2.was_masked;
	assign payload_byte   = res_s2.payload_byte;
	assign last           = res_s2.last;

	// A result that the parser yields is always captured.
	`ASSERT_NXT(a_res_captured, step && res.hit, valid_s2)
	// An error result leaves the parser dead.
	`ASSERT_NXT(a_err_kills, step && res.hit && res.kind == KIND_ERROR, dead)
	// A dead parser never yields another result.
	`ASSERT_IMP(a_dead_silent, dead, !res.hit)
	// Only payload words carry the last flag.
	`ASSERT_IMP(a_last_payload, res.hit && res.last, res.kind == KIND_PAYLOAD)

endmodule
